/* rtl/core/gsu_pkg.sv */
// Shared types and constants of the graph segmentation union-merge core.
// Holds the command/result payload structs and the fixed field limits.
// No dependencies.
package gsu_pkg;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_MERGE = 2'd1,
    OP_SMALL = 2'd2,
    OP_LABEL = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] from_index;
    logic [15:0] to_index;
    logic [16:0] edge_weight;
  } in_t;

  typedef struct packed {
    logic        joined;
    logic [15:0] root_index;
    logic [15:0] region_label;
  } out_t;

  localparam int unsigned  MC_W      = 20;
  localparam int unsigned  SIZE_W    = 17;
  localparam int unsigned  THR_W     = 21;
  localparam int unsigned  LBL_W     = 17;
  localparam int unsigned  RANK_W    = 8;
  localparam int unsigned  WQ_W      = 25;
  localparam int unsigned  THR_FRAC  = 8;

  localparam logic [MC_W-1:0]   MC_RESET   = 20'd76800;
  localparam logic [SIZE_W-1:0] MINS_RESET = 17'd50;
  localparam logic [SIZE_W-1:0] SIZE_SAT   = 17'h1FFFF;
  localparam logic [THR_W-1:0]  THR_SAT    = 21'h1FFFFF;
  localparam logic [LBL_W-1:0]  NO_LABEL   = 17'h10000;
  localparam logic [RANK_W-1:0] RANK_SAT   = 8'hFF;

  localparam logic REG_MERGE_CONSTANT  = 1'b0;
  localparam logic REG_MIN_REGION_SIZE = 1'b1;

endpackage

/* rtl/core/graph_segment_union_merge_core.sv */
// Union-find segmentation core over a pixel entry table in one synchronous RAM.
// Init writes its entry directly; label walks to the root and names it; merge or small-area
// finds both roots and, if joined, links low root under high root (k/size added on merge).
// One command in flight at a time; the finished result sits in an output
// register and the next command is taken once that result is loaded.
// Reset clears control, config registers (k = 76800, min size = 50), label count.
module graph_segment_union_merge_core
  import gsu_pkg::*;
#(
  parameter int unsigned MAX_PIXELS       = 65536,
  parameter int unsigned WEIGHT_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W = $clog2(MAX_PIXELS);

  typedef struct packed {
    logic [IDX_W-1:0]  parent;
    logic [SIZE_W-1:0] size;
    logic [THR_W-1:0]  thr;
    logic [LBL_W-1:0]  label;
    logic [RANK_W-1:0] rank;
  } ent_t;

  localparam int unsigned ENT_W = $bits(ent_t);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_CHK  = 9'b000000100,
    S_CPR  = 9'b000001000,
    S_LAB  = 9'b000010000,
    S_WLO  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_WHI  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  // configuration
  logic [MC_W-1:0]   mc_q;
  logic [SIZE_W-1:0] mins_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mc_q   <= MC_RESET;
      mins_q <= MINS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MERGE_CONSTANT) begin
        mc_q <= pwdata[MC_W-1:0];
      end else begin
        mins_q <= pwdata[SIZE_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MIN_REGION_SIZE) ? {15'b0, mins_q} : {12'b0, mc_q};

  // control and datapath registers
  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [15:0]       from_q, from_d;
  logic [15:0]       to_q, to_d;
  logic [WQ_W-1:0]   wq_q, wq_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic              phase_q, phase_d;
  logic              first_q, first_d;
  ent_t              pw_q, pw_d;
  logic [IDX_W-1:0]  a_q, a_d, b_q, b_d;
  ent_t              aw_q, aw_d, bw_q, bw_d;
  logic [SIZE_W-1:0] szn_q, szn_d;
  logic [THR_W-1:0]  thrn_q, thrn_d;
  logic              joined_q, joined_d;
  logic [15:0]       root_q, root_d;
  logic [15:0]       lbl_q, lbl_d;
  logic [LBL_W-1:0]  nl_q, nl_d;
  out_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // memory and divider hookup
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  ent_t              wr_data, rd_ent;
  logic [ENT_W-1:0]  rd_raw;
  logic              div_start, div_done;
  logic [MC_W-1:0]   div_quo;
  logic [SIZE_W-1:0] div_dv;

  gsu_mem #(
    .DEPTH(MAX_PIXELS),
    .WIDTH(ENT_W),
    .AW   (IDX_W)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_raw),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  assign rd_ent = ent_t'(rd_raw);

  gsu_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(mc_q),
    .divisor_i (div_dv),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // weight aligned to the threshold fraction
  logic [WQ_W-1:0] wq_in;
  always_comb begin
    if (WEIGHT_FRAC_BITS >= THR_FRAC) begin
      wq_in = WQ_W'(in_data_i.edge_weight >> (WEIGHT_FRAC_BITS - THR_FRAC));
    end else begin
      wq_in = WQ_W'(in_data_i.edge_weight) << (THR_FRAC - WEIGHT_FRAC_BITS);
    end
  end

  logic              in_fire;
  logic              from_ok, to_ok;
  ent_t              cw;
  logic              at_root;
  logic              a_hi;
  logic [IDX_W-1:0]  hi_idx, lo_idx;
  ent_t              hi_w, lo_w;
  logic              join_ok;
  logic [SIZE_W:0]   sz_sum;
  logic [SIZE_W-1:0] sz_sat;
  logic [WQ_W:0]     thr_sum;
  ent_t              ent_tmp;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign from_ok    = 32'(in_data_i.from_index) < MAX_PIXELS;
  assign to_ok      = 32'(in_data_i.to_index) < MAX_PIXELS;

  assign cw      = first_q ? rd_ent : pw_q;
  assign at_root = (rd_ent.parent == cur_q) || (32'(rd_ent.parent) >= MAX_PIXELS);

  assign a_hi   = !(aw_q.rank < bw_q.rank);
  assign hi_idx = a_hi ? a_q : b_q;
  assign lo_idx = a_hi ? b_q : a_q;
  assign hi_w   = a_hi ? aw_q : bw_q;
  assign lo_w   = a_hi ? bw_q : aw_q;
  assign sz_sum = {1'b0, aw_q.size} + {1'b0, bw_q.size};
  assign sz_sat = sz_sum[SIZE_W] ? SIZE_SAT : sz_sum[SIZE_W-1:0];

  always_comb begin
    if (op_q == OP_MERGE) begin
      join_ok = (wq_q <= WQ_W'(aw_q.thr)) && (wq_q <= WQ_W'(bw_q.thr));
    end else begin
      join_ok = (aw_q.size < mins_q) || (bw_q.size < mins_q);
    end
  end

  assign thr_sum = {1'b0, wq_q} + (WQ_W + 1)'(div_quo);
  // divisor is the joined size, taken as the low root is written
  assign div_dv  = (sz_sat == '0) ? SIZE_W'(1) : sz_sat;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    from_d      = from_q;
    to_d        = to_q;
    wq_d        = wq_q;
    cur_d       = cur_q;
    phase_d     = phase_q;
    first_d     = first_q;
    pw_d        = pw_q;
    a_d         = a_q;
    aw_d        = aw_q;
    b_d         = b_q;
    bw_d        = bw_q;
    szn_d       = szn_q;
    thrn_d      = thrn_q;
    joined_d    = joined_q;
    root_d      = root_q;
    lbl_d       = lbl_q;
    nl_d        = nl_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    rd_en       = 1'b0;
    rd_addr     = cur_q;
    wr_en       = 1'b0;
    wr_addr     = cur_q;
    wr_data     = pw_q;
    ent_tmp     = pw_q;
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d     = in_data_i.op;
          from_d   = in_data_i.from_index;
          to_d     = in_data_i.to_index;
          wq_d     = wq_in;
          joined_d = 1'b0;
          root_d   = in_data_i.from_index;
          lbl_d    = '0;
          cur_d    = IDX_W'(in_data_i.from_index);
          phase_d  = 1'b0;
          if (!from_ok) begin
            state_d = S_DONE;
          end else if (in_data_i.op == OP_INIT) begin
            ent_tmp.parent = IDX_W'(in_data_i.from_index);
            ent_tmp.size   = SIZE_W'(1);
            ent_tmp.thr    = THR_W'(mc_q);
            ent_tmp.label  = NO_LABEL;
            ent_tmp.rank   = '0;
            wr_en   = 1'b1;
            wr_addr = IDX_W'(in_data_i.from_index);
            wr_data = ent_tmp;
            if (in_data_i.from_index == '0) begin
              nl_d = '0;
            end
            state_d = S_DONE;
          end else if (in_data_i.op == OP_LABEL || to_ok) begin
            state_d = S_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        rd_addr = cur_q;
        first_d = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        // walk parent links until an entry points at itself or past the table
        first_d = 1'b0;
        if (at_root) begin
          ent_tmp        = cw;
          ent_tmp.parent = cur_q;
          pw_d           = ent_tmp;
          if (!phase_q) begin
            a_d  = cur_q;
            aw_d = rd_ent;
          end else begin
            b_d  = cur_q;
            bw_d = rd_ent;
          end
          state_d = S_CPR;
        end else begin
          if (first_q) begin
            pw_d = rd_ent;
          end
          cur_d   = rd_ent.parent;
          rd_en   = 1'b1;
          rd_addr = rd_ent.parent;
        end
      end
      S_CPR: begin
        // compress the start pixel's link straight to the root
        wr_en   = 1'b1;
        wr_addr = phase_q ? IDX_W'(to_q) : IDX_W'(from_q);
        wr_data = pw_q;
        if (!phase_q) begin
          root_d = 16'(a_q);
          if (op_q == OP_LABEL) begin
            state_d = S_LAB;
          end else begin
            phase_d = 1'b1;
            cur_d   = IDX_W'(to_q);
            state_d = S_RD;
          end
        end else if (a_q != b_q && join_ok) begin
          state_d = S_WLO;
        end else begin
          state_d = S_DONE;
        end
      end
      S_LAB: begin
        if (aw_q.label[LBL_W-1]) begin
          ent_tmp       = aw_q;
          ent_tmp.label = {1'b0, nl_q[15:0]};
          wr_en   = 1'b1;
          wr_addr = a_q;
          wr_data = ent_tmp;
          lbl_d   = nl_q[15:0];
          if (nl_q != SIZE_SAT) begin
            nl_d = nl_q + 1'b1;
          end
        end else begin
          lbl_d = aw_q.label[15:0];
        end
        state_d = S_DONE;
      end
      S_WLO: begin
        ent_tmp        = lo_w;
        ent_tmp.parent = hi_idx;
        wr_en    = 1'b1;
        wr_addr  = lo_idx;
        wr_data  = ent_tmp;
        szn_d    = sz_sat;
        thrn_d   = hi_w.thr;
        joined_d = 1'b1;
        root_d   = 16'(hi_idx);
        state_d  = (op_q == OP_MERGE) ? S_DIV : S_WHI;
      end
      S_DIV: begin
        if (div_done) begin
          thrn_d  = (thr_sum > (WQ_W + 1)'(THR_SAT)) ? THR_SAT : thr_sum[THR_W-1:0];
          state_d = S_WHI;
        end
      end
      S_WHI: begin
        ent_tmp      = hi_w;
        ent_tmp.size = szn_q;
        ent_tmp.thr  = thrn_q;
        if (aw_q.rank == bw_q.rank && hi_w.rank != RANK_SAT) begin
          ent_tmp.rank = hi_w.rank + 1'b1;
        end
        wr_en   = 1'b1;
        wr_addr = hi_idx;
        wr_data = ent_tmp;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.joined       = joined_q;
          out_d.root_index   = root_q;
          out_d.region_label = lbl_q;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // start the divider as the low root is written
    if (state_q == S_WLO && op_q == OP_MERGE) begin
      div_start = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      nl_q        <= '0;
      phase_q     <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      nl_q        <= nl_d;
      phase_q     <= phase_d;
      first_q     <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    from_q   <= from_d;
    to_q     <= to_d;
    wq_q     <= wq_d;
    cur_q    <= cur_d;
    pw_q     <= pw_d;
    a_q      <= a_d;
    aw_q     <= aw_d;
    b_q      <= b_d;
    bw_q     <= bw_d;
    szn_q    <= szn_d;
    thrn_q   <= thrn_d;
    joined_q <= joined_d;
    root_q   <= root_d;
    lbl_q    <= lbl_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("table read and write in the same cycle");

  a_div_only_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside its wait state");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> (state_q == S_DONE))
    else $error("result dropped while output register was full");

  a_join_label_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.joined) |-> (out_data_o.region_label == '0))
    else $error("joined result carries a label");

endmodule

/* rtl/core/gsu_mem.sv */
// Pixel entry table: single write port, single read port, registered read.
// Depends on nothing; width and depth come from the instantiating module.
module gsu_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned WIDTH = 79,
  parameter int unsigned AW    = 16
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/gsu_div.sv */
// Restoring divider for the threshold term k/size, one quotient bit a cycle.
// Depends on gsu_pkg for the operand widths.
module gsu_div
  import gsu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MC_W-1:0]   dividend_i,
  input  logic [SIZE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [MC_W-1:0]   quotient_o
);

  localparam int unsigned CNT_W = $clog2(MC_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [MC_W-1:0]   quo_q, quo_d;
  logic [SIZE_W-1:0] dv_q, dv_d;
  logic [SIZE_W:0]   trial;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dv_d   = dv_q;
    trial  = {rem_q, quo_q[MC_W-1]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dv_d   = divisor_i;
      cnt_d  = CNT_W'(MC_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dv_q}) begin
        rem_d = SIZE_W'(trial - {1'b0, dv_q});
        quo_d = {quo_q[MC_W-2:0], 1'b1};
      end else begin
        rem_d = SIZE_W'(trial);
        quo_d = {quo_q[MC_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dv_q  <= dv_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
